@@ sv/sfsf_pkg.sv @@
// shared types, constants and the payload signature match for the syn flood filter
// used by sfsf_regs, sfsf_cell and syn_flood_and_signature_filter
package sfsf_pkg;

  localparam int TABLE_ENTRIES = 256;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;

  localparam logic [31:0] THRESHOLD_RESET = 32'd1000;
  localparam logic [63:0] WINDOW_RESET    = 64'd100000000;
  localparam logic [31:0] COUNT_MAX       = 32'hFFFF_FFFF;

  // register select values, compared with paddr[3] (byte offsets 0x0 and 0x8)
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_WINDOW    = 1'b1;

  localparam logic [1:0] EVENT_NONE  = 2'd0;
  localparam logic [1:0] EVENT_FLOOD = 2'd1;
  localparam logic [1:0] EVENT_UNION = 2'd2;

  localparam logic [7:0] CASE_BIT = 8'h20;
  localparam logic [7:0] CHAR_U = 8'h75;  // 'u'
  localparam logic [7:0] CHAR_N = 8'h6E;  // 'n'
  localparam logic [7:0] CHAR_I = 8'h69;  // 'i'
  localparam logic [7:0] CHAR_O = 8'h6F;  // 'o'

  typedef struct packed {
    logic [15:0] ethertype;
    logic [7:0]  ip_protocol;
    logic [31:0] source_address;
    logic        headers_present;
    logic        syn_bit;
    logic        ack_bit;
    logic        payload_present;
    logic [39:0] payload_head;
    logic [63:0] now_ns;
  } sfsf_in_t;

  typedef struct packed {
    logic        drop;
    logic        event_valid;
    logic [1:0]  event_id;
    logic [31:0] event_address;
  } sfsf_out_t;

  typedef struct packed {
    logic [31:0] flood_threshold;
    logic [63:0] window_ns;
  } sfsf_cfg_t;

  // request travelling down the cell chain
  typedef struct packed {
    logic        valid;
    logic        track;   // tcp syn without ack, goes through the table
    logic        found;   // an entry has already taken this request
    logic        flood;
    logic        sig;     // union signature seen in payload
    logic [31:0] addr;
    logic [63:0] now;
  } sfsf_req_t;

  function automatic logic union_match(input logic [39:0] head);
    logic [7:0] word [5];
    logic       ok;
    word[0] = CHAR_U;
    word[1] = CHAR_N;
    word[2] = CHAR_I;
    word[3] = CHAR_O;
    word[4] = CHAR_N;
    ok = 1'b1;
    for (int k = 0; k < 5; k++) begin
      if ((head[39 - 8 * k -: 8] | CASE_BIT) != word[k]) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

@@ sv/syn_flood_and_signature_filter.sv @@
// Per-source SYN flood and UNION signature filter. Each frame summary request runs down a
// chain of TABLE_ENTRIES registered cells, every cell holding one source entry; a request
// is taken every cycle while the output is not stalled, and its verdict leaves the cell
// chain through the output register, in order. A stalled output freezes the whole chain.
// Registers over APB: flood_threshold at 0x0, window_ns at 0x8 (64-bit data). After reset
// the table is empty at once, no clearing pass. Depends on sfsf_pkg, sfsf_regs, sfsf_cell.
module syn_flood_and_signature_filter (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sfsf_pkg::sfsf_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sfsf_pkg::sfsf_out_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready
);
  import sfsf_pkg::*;

  sfsf_cfg_t                  cfg;
  sfsf_req_t                  chain [TABLE_ENTRIES + 1];
  logic [TABLE_ENTRIES - 1:0] ent_v;
  logic                       adv;
  logic                       examined;
  sfsf_req_t                  tail;
  sfsf_out_t                  result;

  sfsf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  assign examined = in_data.headers_present && (in_data.ethertype == ETHERTYPE_IPV4)
                    && (in_data.ip_protocol == PROTO_TCP);

  always_comb begin
    chain[0].valid = in_valid;
    chain[0].track = examined && in_data.syn_bit && !in_data.ack_bit;
    chain[0].found = 1'b0;
    chain[0].flood = 1'b0;
    chain[0].sig   = examined && in_data.payload_present
                     && union_match(in_data.payload_head);
    chain[0].addr  = in_data.source_address;
    chain[0].now   = in_data.now_ns;
  end

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    sfsf_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .cfg       (cfg),
      .req_in    (chain[i]),
      .req_out   (chain[i + 1]),
      .ent_valid (ent_v[i])
    );
  end

  assign tail = chain[TABLE_ENTRIES];

  always_comb begin
    result = '0;
    if (tail.flood) begin
      result.event_id = EVENT_FLOOD;
    end else if (tail.sig) begin
      result.event_id = EVENT_UNION;
    end else begin
      result.event_id = EVENT_NONE;
    end
    result.drop          = result.event_id != EVENT_NONE;
    result.event_valid   = result.drop;
    result.event_address = result.drop ? tail.addr : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= tail.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= result;
    end
  end

`ifndef SYNTHESIS
  // occupied entries always form a block starting at the bottom of the table
  a_fill_prefix: assert property (@(posedge clk) disable iff (rst)
    $onehot({1'b0, ent_v} + {{TABLE_ENTRIES{1'b0}}, 1'b1}))
    else $error("table entries not filled from the bottom");

  // at most one new source enters per cycle
  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    $countones(ent_v) <= $past($countones(ent_v)) + 1)
    else $error("more than one entry claimed in a cycle");

  // a flood verdict needs a tracked source in the table
  a_flood_tracked: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.event_id == EVENT_FLOOD) |-> (ent_v != '0))
    else $error("flood event with an empty table");

  // a frozen chain keeps the table unchanged
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(ent_v))
    else $error("table changed while the chain was stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && (ent_v == '0))
    else $error("state not cleared by reset");
`endif

endmodule

@@ sv/sfsf_regs.sv @@
// apb configuration registers: flood threshold and syn window
// depends on sfsf_pkg
module sfsf_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  output sfsf_pkg::sfsf_cfg_t cfg
);
  import sfsf_pkg::*;

  logic wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.flood_threshold <= THRESHOLD_RESET;
      cfg.window_ns       <= WINDOW_RESET;
    end else if (wr_en) begin
      unique case (paddr[3])
        REG_THRESHOLD: cfg.flood_threshold <= pwdata[31:0];
        REG_WINDOW:    cfg.window_ns       <= pwdata;
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      REG_THRESHOLD: prdata = {32'd0, cfg.flood_threshold};
      REG_WINDOW:    prdata = cfg.window_ns;
      default:       prdata = '0;
    endcase
  end

endmodule

@@ sv/sfsf_cell.sv @@
// one table entry of the source tracker plus one stage of the request chain
// depends on sfsf_pkg
module sfsf_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  sfsf_pkg::sfsf_cfg_t cfg,
  input  sfsf_pkg::sfsf_req_t req_in,
  output sfsf_pkg::sfsf_req_t req_out,
  output logic                ent_valid
);
  import sfsf_pkg::*;

  logic [31:0] key;
  logic [31:0] cnt;
  logic [63:0] stamp;

  logic        probe;
  logic        hit;
  logic        claim;
  logic [63:0] gap;
  logic [31:0] cnt_next;
  sfsf_req_t   req_next;

  assign probe = req_in.valid && req_in.track && !req_in.found;
  assign hit   = probe && ent_valid && (key == req_in.addr);
  // entries fill from the bottom, so the first empty cell seen is the lowest free one
  assign claim = probe && !ent_valid;
  assign gap   = req_in.now - stamp;

  always_comb begin
    if (claim || (gap > cfg.window_ns)) begin
      cnt_next = 32'd1;
    end else if (cnt == COUNT_MAX) begin
      cnt_next = cnt;
    end else begin
      cnt_next = cnt + 32'd1;
    end
  end

  always_comb begin
    req_next = req_in;
    if (hit || claim) begin
      req_next.found = 1'b1;
      req_next.flood = cnt_next > cfg.flood_threshold;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= 1'b0;
      req_out   <= '0;
    end else if (adv) begin
      req_out <= req_next;
      if (hit || claim) begin
        ent_valid <= 1'b1;
        key       <= req_in.addr;
        cnt       <= cnt_next;
        stamp     <= req_in.now;
      end
    end
  end

endmodule

@@ tb/sv/syn_flood_and_signature_filter_checker.sv @@
// scoreboard for the syn flood and signature filter: tracks register writes, predicts
// each frame verdict from its own per-source syn table and compares results in order
// depends on sfsf_pkg
module syn_flood_and_signature_filter_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  sfsf_pkg::sfsf_in_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  sfsf_pkg::sfsf_out_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [63:0]         pwdata,
  input  logic [63:0]         prdata,
  input  logic                pready,
  output int                  mismatches,
  output int                  waiting
);
  timeunit 1ns;
  timeprecision 1ps;
  import sfsf_pkg::*;

  logic [31:0] src_key   [TABLE_ENTRIES];
  logic [31:0] syn_cnt   [TABLE_ENTRIES];
  logic [63:0] syn_seen  [TABLE_ENTRIES];
  logic        tracked   [TABLE_ENTRIES];
  logic [31:0] threshold;
  logic [63:0] window;
  sfsf_out_t   verdict_q [$];
  int          fail_tally = 0;

  function automatic logic signature_hit(input logic [39:0] head);
    return (head | {5{CASE_BIT}}) == {CHAR_U, CHAR_N, CHAR_I, CHAR_O, CHAR_N};
  endfunction

  // bumps the syn count of a source, returns 1 when it is over the threshold
  function automatic logic flood_update(input logic [31:0] addr, input logic [63:0] now);
    int slot;
    int spare;
    slot = -1;
    spare = -1;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (tracked[i]) begin
        if (slot < 0 && src_key[i] == addr) slot = i;
      end else if (spare < 0) begin
        spare = i;
      end
    end
    if (slot < 0) begin
      // table full: untracked source never floods
      if (spare < 0) return 1'b0;
      slot = spare;
      tracked[slot] = 1'b1;
      src_key[slot] = addr;
      syn_cnt[slot] = 32'd1;
    end else if (now - syn_seen[slot] > window) begin
      syn_cnt[slot] = 32'd1;
    end else if (syn_cnt[slot] != COUNT_MAX) begin
      syn_cnt[slot] = syn_cnt[slot] + 32'd1;
    end
    syn_seen[slot] = now;
    return syn_cnt[slot] > threshold;
  endfunction

  function automatic sfsf_out_t judge_frame(input sfsf_in_t f);
    sfsf_out_t v;
    logic [1:0] id;
    id = EVENT_NONE;
    if (f.headers_present && f.ethertype == ETHERTYPE_IPV4 && f.ip_protocol == PROTO_TCP) begin
      if (f.syn_bit && !f.ack_bit && flood_update(f.source_address, f.now_ns)) begin
        id = EVENT_FLOOD;
      end else if (f.payload_present && signature_hit(f.payload_head)) begin
        id = EVENT_UNION;
      end
    end
    v.drop = (id != EVENT_NONE);
    v.event_valid = v.drop;
    v.event_id = id;
    v.event_address = v.drop ? f.source_address : 32'd0;
    return v;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_tally++;
    end
  endtask

  task automatic check_result(input sfsf_out_t got);
    sfsf_out_t want;
    want = verdict_q.pop_front();
    check_field("drop", 64'(want.drop), 64'(got.drop));
    check_field("event_valid", 64'(want.event_valid), 64'(got.event_valid));
    check_field("event_id", 64'(want.event_id), 64'(got.event_id));
    check_field("event_address", 64'(want.event_address), 64'(got.event_address));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        tracked[i] = 1'b0;
        src_key[i] = '0;
        syn_cnt[i] = '0;
        syn_seen[i] = '0;
      end
      threshold = THRESHOLD_RESET;
      window = WINDOW_RESET;
      verdict_q.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[3] == REG_WINDOW) window = pwdata;
          else threshold = pwdata[31:0];
        end else if (paddr[3] == REG_WINDOW) begin
          check_field("window_ns", window, prdata);
        end else begin
          check_field("flood_threshold", 64'(threshold), 64'(prdata[31:0]));
        end
      end
      if (in_valid && in_ready) verdict_q.push_back(judge_frame(in_data));
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          $error("result with no request waiting: drop %0h event_id %0h",
                 out_data.drop, out_data.event_id);
          fail_tally++;
        end else begin
          check_result(out_data);
        end
      end
    end
    mismatches <= fail_tally;
    waiting <= verdict_q.size();
  end

endmodule

@@ tb/sv/syn_flood_and_signature_filter_tb.sv @@
// top of the syn flood and signature filter testbench: clock, reset, apb register
// traffic and frame stimulus with random idling; verdict from the checker's counts
// depends on sfsf_pkg, syn_flood_and_signature_filter and its checker
module syn_flood_and_signature_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sfsf_pkg::*;

  localparam logic [3:0]  ADDR_THRESHOLD = {REG_THRESHOLD, 3'b000};
  localparam logic [3:0]  ADDR_WINDOW    = {REG_WINDOW, 3'b000};
  localparam logic [15:0] ETHERTYPE_IPV6 = 16'h86DD;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [63:0] TIME_MAX       = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int          POOL_SIZE      = 12;
  localparam int          PHASE_ITEMS    = 70;
  localparam int          SETTLE_CYCLES  = 2 * TABLE_ENTRIES + 20;
  localparam int          CYCLE_LIMIT    = 500000;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  sfsf_in_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  sfsf_out_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  int          mismatches;
  int          waiting;

  logic        steady = 1'b0;   // no idling on either side while set
  int          ready_left = 0;
  int          cycle_count = 0;
  logic [63:0] clock_ns = '0;
  logic [63:0] win_now = WINDOW_RESET;
  logic [31:0] pool [POOL_SIZE];

  syn_flood_and_signature_filter dut (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  syn_flood_and_signature_filter_checker verdict_check (
    .clk, .rst, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .mismatches, .waiting
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  // result side: ready bursts broken by stalls
  always @(posedge clk) begin
    if (ready_left > 0) begin
      ready_left <= ready_left - 1;
    end else if (steady || $urandom_range(0, 2) != 0) begin
      out_ready <= 1'b1;
      ready_left <= $urandom_range(0, 15);
    end else begin
      out_ready <= 1'b0;
      ready_left <= pause_len() + 1;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // bit 5 of each letter cleared where upper is set
  function automatic logic [39:0] spell_union(input logic [4:0] upper);
    logic [39:0] w;
    w = {CHAR_U, CHAR_N, CHAR_I, CHAR_O, CHAR_N};
    for (int k = 0; k < 5; k++) begin
      if (upper[k]) w[8 * k + 5] = 1'b0;
    end
    return w;
  endfunction

  function automatic logic [39:0] pick_payload();
    logic [39:0] w;
    int r;
    int b;
    int pos;
    r = $urandom_range(0, 99);
    if (r < 25) return spell_union(5'($urandom));
    if (r < 35) begin
      // near miss: one bit off, never the case bit
      w = spell_union(5'($urandom));
      b = $urandom_range(0, 6);
      if (b >= 5) b++;
      pos = 8 * $urandom_range(0, 4) + b;
      w[pos] = ~w[pos];
      return w;
    end
    return {8'($urandom), $urandom};
  endfunction

  function automatic logic [63:0] next_time();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) clock_ns = clock_ns + 64'($urandom_range(0, 40));
    else if (r < 80) clock_ns = clock_ns + win_now + 64'($urandom_range(0, 2)) - 64'd1;
    else if (r < 90) clock_ns = rand64();
    else clock_ns = clock_ns - 64'($urandom_range(1, 1000));
    return clock_ns;
  endfunction

  function automatic sfsf_in_t tcp_frame(input logic [31:0] addr, input logic syn,
                                         input logic ack, input logic [63:0] now,
                                         input logic present, input logic [39:0] head);
    sfsf_in_t f;
    f.ethertype = ETHERTYPE_IPV4;
    f.ip_protocol = PROTO_TCP;
    f.source_address = addr;
    f.headers_present = 1'b1;
    f.syn_bit = syn;
    f.ack_bit = ack;
    f.payload_present = present;
    f.payload_head = head;
    f.now_ns = now;
    return f;
  endfunction

  function automatic sfsf_in_t random_frame();
    sfsf_in_t f;
    logic [191:0] noise;
    int r;
    r = $urandom_range(0, 99);
    f = tcp_frame(pool[$urandom_range(0, POOL_SIZE - 1)], 1'b1, 1'b0, next_time(),
                  $urandom_range(0, 3) != 0, pick_payload());
    if (r < 55) begin
      // syn from a known source, the common case
    end else if (r < 65) begin
      f.source_address = $urandom;
    end else if (r < 75) begin
      f.ack_bit = 1'b1;
      f.syn_bit = 1'($urandom);
    end else if (r < 87) begin
      noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      f = noise[$bits(sfsf_in_t) - 1:0];
    end else if ($urandom_range(0, 1) != 0) begin
      f.headers_present = 1'b0;
    end else begin
      f.ip_protocol = 8'($urandom);
    end
    return f;
  endfunction

  task automatic push_frame(input sfsf_in_t f);
    int gap;
    gap = steady ? 0 : pause_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= f;
    do @(posedge clk); while (!in_ready);
  endtask

  // stop sending and wait until every verdict is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
  endtask

  task automatic reg_access(input logic wr, input logic [3:0] addr, input logic [63:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle(input logic [31:0] thr, input logic [63:0] win);
    reg_access(1'b1, ADDR_THRESHOLD, {32'd0, thr});
    reg_access(1'b1, ADDR_WINDOW, win);
    reg_access(1'b0, ADDR_THRESHOLD, '0);
    reg_access(1'b0, ADDR_WINDOW, '0);
    win_now = win;
  endtask

  initial begin
    sfsf_in_t    f;
    logic [31:0] src_a;
    logic [31:0] src_b;
    logic [31:0] thr_list [5];
    logic [63:0] win_list [5];

    for (int i = 0; i < POOL_SIZE; i++) pool[i] = $urandom;
    src_a = pool[0];
    src_b = pool[1];
    thr_list = '{32'd2, 32'd0, 32'd4, 32'hFFFF_FFFF, 32'd1};
    win_list = '{64'd1000, 64'd0, TIME_MAX, 64'd300, rand64()};

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    reg_access(1'b0, ADDR_THRESHOLD, '0);
    reg_access(1'b0, ADDR_WINDOW, '0);

    // reset settings: filtering rules and window edges
    push_frame('0);
    push_frame('1);
    f = tcp_frame(src_a, 1'b1, 1'b0, 64'd3, 1'b1, spell_union(5'b11111));
    f.ethertype = ETHERTYPE_IPV6;
    push_frame(f);
    f.ethertype = ETHERTYPE_IPV4;
    f.ip_protocol = PROTO_UDP;
    push_frame(f);
    f.ip_protocol = PROTO_TCP;
    f.headers_present = 1'b0;
    push_frame(f);
    push_frame(tcp_frame(src_b, 1'b0, 1'b0, 64'd3, 1'b1, spell_union(5'b00000)));
    push_frame(tcp_frame(src_b, 1'b0, 1'b1, 64'd3, 1'b1, spell_union(5'b10101)));
    push_frame(tcp_frame(src_b, 1'b0, 1'b0, 64'd3, 1'b1, spell_union(5'b11111) ^ 40'd1));
    push_frame(tcp_frame(src_b, 1'b0, 1'b0, 64'd3, 1'b0, spell_union(5'b11111)));
    push_frame(tcp_frame(src_a, 1'b1, 1'b1, 64'd3, 1'b0, '0));
    push_frame(tcp_frame(src_a, 1'b1, 1'b0, 64'd100, 1'b0, '0));
    push_frame(tcp_frame(src_a, 1'b1, 1'b0, 64'd100 + WINDOW_RESET, 1'b0, '0));
    push_frame(tcp_frame(src_a, 1'b1, 1'b0, 64'd101 + 2 * WINDOW_RESET, 1'b0, '0));
    push_frame(tcp_frame(src_a, 1'b1, 1'b0, 64'd50, 1'b0, '0));
    push_frame(tcp_frame(32'd0, 1'b1, 1'b0, TIME_MAX, 1'b1, spell_union(5'b11111)));
    // time wraps past zero: difference of one, count continues
    push_frame(tcp_frame(32'd0, 1'b1, 1'b0, 64'd0, 1'b0, '0));
    push_frame(tcp_frame(32'hFFFF_FFFF, 1'b1, 1'b0, 64'd7, 1'b1, '1));
    drain();

    // any tracked syn floods, window never expires
    settle(32'd0, TIME_MAX);
    push_frame(tcp_frame(src_a, 1'b1, 1'b0, 64'd0, 1'b0, '0));
    push_frame(tcp_frame(src_b, 1'b1, 1'b0, 64'd9, 1'b1, spell_union(5'b11111)));
    push_frame(tcp_frame(src_b, 1'b1, 1'b1, 64'd9, 1'b1, spell_union(5'b11111)));
    f = tcp_frame(src_b, 1'b1, 1'b0, 64'd2, 1'b1, spell_union(5'b00000));
    f.headers_present = 1'b0;
    push_frame(f);
    drain();

    // zero window: only a syn at the same instant continues a count
    settle(32'hFFFF_FFFF, 64'd0);
    push_frame(tcp_frame(src_a, 1'b1, 1'b0, 64'd5, 1'b0, '0));
    push_frame(tcp_frame(src_a, 1'b1, 1'b0, 64'd5, 1'b0, '0));
    push_frame(tcp_frame(src_a, 1'b1, 1'b0, 64'd6, 1'b0, '0));
    drain();

    for (int p = 0; p < 5; p++) begin
      settle(thr_list[p], win_list[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 35 == 0) steady = ($urandom_range(0, 3) == 0);
        push_frame(random_frame());
      end
      drain();
    end

    // fill the table with fresh sources, then run with it full
    settle(32'd0, TIME_MAX);
    steady = 1'b0;
    for (int n = 0; n < TABLE_ENTRIES - 16; n++) begin
      push_frame(tcp_frame($urandom, 1'b1, 1'b0, next_time(), 1'($urandom), pick_payload()));
    end
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if (n % 35 == 0) steady = ($urandom_range(0, 3) == 0);
      push_frame(random_frame());
    end
    drain();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && waiting == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/sfsf_pkg.sv
sv/sfsf_regs.sv
sv/sfsf_cell.sv
sv/syn_flood_and_signature_filter.sv
tb/sv/syn_flood_and_signature_filter_checker.sv
tb/sv/syn_flood_and_signature_filter_tb.sv
